@@ src/pcw_pkg.sv @@
// Package for the windowed Pearson correlation core.
// Holds the back-end state type, configuration register indexes and queue flags.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcw_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int WINDOW_W = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_START = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_END = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_END_EN = 2'd2;

    localparam logic [WINDOW_W-1:0] WINDOW_END_RESET = 20'hFFFFF;

    localparam int COEF_W = 16;
    localparam int SEARCH_SHIFT = 32;
    localparam logic [COEF_W-1:0] COEF_ONE = 16'h8000;
    localparam logic [COEF_W-1:0] COEF_MAX = 16'h7FFF;

    typedef struct packed {
        logic in_window;
        logic last;
    } pcw_flags_t;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_CHECK,
        ST_PROD,
        ST_RHS,
        ST_SQ,
        ST_SRCH,
        ST_DONE
    } pcw_state_t;

endpackage

`default_nettype wire

@@ src/pearson_correlation_window_core.sv @@
// Top level of the windowed Pearson correlation core.
// Depends on pcw_pkg, pcw_front, pcw_queue and pcw_back.
//
//   channel  signals                                   direction
//   input    in_valid, in_ready, sample_a/b, last      pairs in
//   output   out_valid, out_ready, correlation, ...    one result per series
//   config   cfg_we, cfg_index, cfg_data               register writes
//
// Pairs are accepted one per cycle while the queue has room, pass through the
// queue and the registered product stage, and are summed one per cycle while
// the back end is accumulating. The pair marked last starts the final
// computation on the shared shift-and-add multiplier: six moment products, two
// more products and up to sixteen binary search steps, each step one product.
// Pairs keep entering the four-entry queue meanwhile and stall once it is full.
// Reset is asynchronous and active low and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module pearson_correlation_window_core
    import pcw_pkg::*;
#(
    parameter int MAX_LEN = 1048576,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [WINDOW_W-1:0]           cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_a,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_b,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COEF_W-1:0]           correlation,
    output logic                               valid_res,
    output logic [$clog2(MAX_LEN+1)-1:0]       pair_count
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int FW = 4 * SAMPLE_BITS + 4 * CNT_W + 36;
    localparam int FLAG_W = $bits(pcw_flags_t);
    localparam int QW = 2 * SAMPLE_BITS + FLAG_W;

    logic q_full, q_push, q_pop, q_not_empty;
    pcw_flags_t front_flags;
    logic [QW-1:0] q_out;

    pcw_front #(
        .MAX_LEN(MAX_LEN),
        .CNT_W  (CNT_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .last     (last),
        .q_full   (q_full),
        .in_ready (in_ready),
        .push     (q_push),
        .flags    (front_flags)
    );

    pcw_queue #(
        .W(QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data({sample_a, sample_b, front_flags}),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .pop_data (q_out)
    );

    pcw_back #(
        .SB   (SAMPLE_BITS),
        .CNT_W(CNT_W),
        .FW   (FW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_a        ($signed(q_out[QW-1 -: SAMPLE_BITS])),
        .q_b        ($signed(q_out[FLAG_W +: SAMPLE_BITS])),
        .q_flags    (pcw_flags_t'(q_out[FLAG_W-1:0])),
        .q_pop      (q_pop),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .correlation(correlation),
        .valid_res  (valid_res),
        .pair_count (pair_count)
    );

endmodule

`default_nettype wire

@@ src/pcw_queue.sv @@
// Four-entry transaction queue between the front and the back end.
// Depends on nothing but its width parameter.
`timescale 1ns / 1ps
`default_nettype none

module pcw_queue #(
    parameter int W = 34
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              not_empty,
    output logic [W-1:0]      pop_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic [W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0] count_reg, count_next;

    always_comb
    begin
        full = (count_reg == (PTR_W+1)'(DEPTH));
        not_empty = (count_reg != '0);
        pop_data = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ src/pcw_front.sv @@
// Front end: configuration registers, pair numbering and window classification.
// Depends on pcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcw_front
    import pcw_pkg::*;
#(
    parameter int MAX_LEN = 1048576,
    parameter int CNT_W = 21
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WINDOW_W-1:0]    cfg_data,
    input  wire logic                   in_valid,
    input  wire logic                   last,
    input  wire logic                   q_full,
    output logic                        in_ready,
    output logic                        push,
    output pcw_flags_t                  flags
);

    localparam int CMP_W = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;

    logic [WINDOW_W-1:0] start_reg;
    logic [WINDOW_W-1:0] end_reg;
    logic end_en_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CMP_W-1:0] idx_cmp;

    always_comb
    begin
        in_ready = !q_full;
        push = in_valid && !q_full;
        idx_cmp = CMP_W'(idx_reg);
        flags.last = last;
        flags.in_window = (idx_reg < CNT_W'(MAX_LEN)) && (idx_cmp >= CMP_W'(start_reg))
            && (!end_en_reg || (idx_cmp <= CMP_W'(end_reg)));
        idx_next = idx_reg;
        if (push)
        begin
            if (last)
            begin
                idx_next = '0;
            end
            else if (idx_reg < CNT_W'(MAX_LEN))
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg <= WINDOW_END_RESET;
            end_en_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_START: start_reg <= cfg_data;
                    CFG_WINDOW_END: end_reg <= cfg_data;
                    CFG_WINDOW_END_EN: end_en_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ src/pcw_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle, modulo 2^W.
// Ends as soon as the remaining multiplier bits are zero. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pcw_mul #(
    parameter int W = 184
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] x,
    input  wire logic [W-1:0] y,
    output logic              done,
    output logic [W-1:0]      p
);

    logic busy_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] xs_reg;
    logic [W-1:0] ys_reg;

    always_comb
    begin
        done = busy_reg && (ys_reg == '0);
        p = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            xs_reg <= x;
            ys_reg <= y;
        end
        else if (busy_reg && !done)
        begin
            if (ys_reg[0])
            begin
                acc_reg <= acc_reg + xs_reg;
            end
            xs_reg <= xs_reg << 1;
            ys_reg <= ys_reg >> 1;
        end
    end

endmodule

`default_nettype wire

@@ src/pcw_back.sv @@
// Back end: accumulates the sums of the in-window pairs and, on the last pair, works out the
// coefficient with the shared multiplier. Depends on pcw_pkg and pcw_mul.
`timescale 1ns / 1ps
`default_nettype none

module pcw_back
    import pcw_pkg::*;
#(
    parameter int SB = 16,
    parameter int CNT_W = 21,
    parameter int FW = 184
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire logic signed [SB-1:0] q_a,
    input  wire logic signed [SB-1:0] q_b,
    input  pcw_flags_t                q_flags,
    output logic                      q_pop,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic signed [COEF_W-1:0]  correlation,
    output logic                      valid_res,
    output logic [CNT_W-1:0]          pair_count
);

    localparam int SA_W = SB + CNT_W;
    localparam int SQ_W = 2 * SB + CNT_W;

    pcw_state_t state_reg, state_next;

    logic s1_valid_reg;
    pcw_flags_t s1_flags_reg;
    logic signed [SB-1:0] s1_a_reg, s1_b_reg;
    logic signed [2*SB-1:0] s1_aa_reg, s1_bb_reg, s1_ab_reg;

    logic signed [SA_W-1:0] sa_reg, sb_reg, sa_next, sb_next;
    logic signed [SQ_W-1:0] saa_reg, sbb_reg, sab_reg, saa_next, sbb_next, sab_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [SA_W-1:0] fin_sa_reg, fin_sb_reg;
    logic signed [SQ_W-1:0] fin_saa_reg, fin_sbb_reg, fin_sab_reg;
    logic [CNT_W-1:0] fin_n_reg;
    logic fin_load;

    logic [FW-1:0] t_reg, va_reg, vb_reg, cv_reg, prod_reg, rhs_reg;
    logic [FW-1:0] t_next, va_next, vb_next, cv_next, prod_next, rhs_next;
    logic [COEF_W-1:0] lo_reg, hi_reg, mid_reg, lo_next, hi_next, mid_next;
    logic [2*COEF_W-1:0] dd_reg, dd_next;
    logic [COEF_W:0] mid_sum;
    logic [COEF_W-1:0] d_val;
    logic neg_reg, neg_next;
    logic [COEF_W-1:0] rc_reg, rc_next;
    logic rv_reg, rv_next;
    logic issued_reg, issued_next;
    logic out_valid_reg, out_valid_next, out_load;
    logic [COEF_W-1:0] out_corr_reg;
    logic out_vres_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    logic mul_start, mul_done;
    logic [FW-1:0] mul_x, mul_y, mul_p;

    pcw_mul #(
        .W(FW)
    ) u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mul_start),
        .x    (mul_x),
        .y    (mul_y),
        .done (mul_done),
        .p    (mul_p)
    );

    always_comb
    begin
        q_pop = q_valid && (state_reg == ST_ACC) && !(s1_valid_reg && s1_flags_reg.last);
        out_valid = out_valid_reg;
        correlation = out_corr_reg;
        valid_res = out_vres_reg;
        pair_count = out_cnt_reg;

        sa_next = sa_reg;
        sb_next = sb_reg;
        saa_next = saa_reg;
        sbb_next = sbb_reg;
        sab_next = sab_reg;
        cnt_next = cnt_reg;
        if (s1_valid_reg && s1_flags_reg.in_window)
        begin
            sa_next = sa_reg + SA_W'(s1_a_reg);
            sb_next = sb_reg + SA_W'(s1_b_reg);
            saa_next = saa_reg + SQ_W'(s1_aa_reg);
            sbb_next = sbb_reg + SQ_W'(s1_bb_reg);
            sab_next = sab_reg + SQ_W'(s1_ab_reg);
            cnt_next = cnt_reg + 1'b1;
        end

        state_next = state_reg;
        fin_load = 1'b0;
        t_next = t_reg;
        va_next = va_reg;
        vb_next = vb_reg;
        cv_next = cv_reg;
        prod_next = prod_reg;
        rhs_next = rhs_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid_reg;
        dd_next = dd_reg;
        neg_next = neg_reg;
        rc_next = rc_reg;
        rv_next = rv_reg;
        issued_next = issued_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_load = 1'b0;
        mul_start = 1'b0;
        mul_x = '0;
        mul_y = '0;
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + 1'b1;
        d_val = {mid_sum[COEF_W-1:1], 1'b0} - 1'b1;

        case (state_reg)
            ST_M1:
            begin
                mul_x = FW'(fin_saa_reg);
                mul_y = FW'(fin_n_reg);
            end
            ST_M2:
            begin
                mul_x = FW'(fin_sa_reg);
                mul_y = FW'(fin_sa_reg);
            end
            ST_M3:
            begin
                mul_x = FW'(fin_sbb_reg);
                mul_y = FW'(fin_n_reg);
            end
            ST_M4:
            begin
                mul_x = FW'(fin_sb_reg);
                mul_y = FW'(fin_sb_reg);
            end
            ST_M5:
            begin
                mul_x = FW'(fin_sab_reg);
                mul_y = FW'(fin_n_reg);
            end
            ST_M6:
            begin
                mul_x = FW'(fin_sa_reg);
                mul_y = FW'(fin_sb_reg);
            end
            ST_PROD:
            begin
                mul_x = va_reg;
                mul_y = vb_reg;
            end
            ST_RHS:
            begin
                mul_x = cv_reg;
                mul_y = cv_reg;
            end
            ST_SRCH:
            begin
                mul_x = prod_reg;
                mul_y = FW'(dd_reg);
            end
            default: ;
        endcase

        case (state_reg)
            ST_ACC:
            begin
                if (s1_valid_reg && s1_flags_reg.last)
                begin
                    fin_load = 1'b1;
                    state_next = ST_M1;
                end
            end
            ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_PROD, ST_RHS, ST_SRCH:
            begin
                if (!issued_reg)
                begin
                    mul_start = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    case (state_reg)
                        ST_M1:
                        begin
                            t_next = mul_p;
                            state_next = ST_M2;
                        end
                        ST_M2:
                        begin
                            va_next = t_reg - mul_p;
                            state_next = ST_M3;
                        end
                        ST_M3:
                        begin
                            t_next = mul_p;
                            state_next = ST_M4;
                        end
                        ST_M4:
                        begin
                            vb_next = t_reg - mul_p;
                            state_next = ST_M5;
                        end
                        ST_M5:
                        begin
                            t_next = mul_p;
                            state_next = ST_M6;
                        end
                        ST_M6:
                        begin
                            cv_next = t_reg - mul_p;
                            state_next = ST_CHECK;
                        end
                        ST_PROD:
                        begin
                            prod_next = mul_p;
                            state_next = ST_RHS;
                        end
                        ST_RHS:
                        begin
                            rhs_next = mul_p << SEARCH_SHIFT;
                            state_next = ST_SQ;
                        end
                        default:
                        begin
                            if (mul_p <= rhs_reg)
                            begin
                                lo_next = mid_reg;
                            end
                            else
                            begin
                                hi_next = mid_reg - 1'b1;
                            end
                            state_next = ST_SQ;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                neg_next = cv_reg[FW-1];
                if ((fin_n_reg != '0) && (va_reg != '0) && (vb_reg != '0)
                    && !va_reg[FW-1] && !vb_reg[FW-1])
                begin
                    lo_next = '0;
                    hi_next = COEF_ONE;
                    state_next = ST_PROD;
                end
                else
                begin
                    rc_next = '0;
                    rv_next = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_SQ:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next = mid_sum[COEF_W:1];
                    dd_next = d_val * d_val;
                    state_next = ST_SRCH;
                end
                else
                begin
                    rv_next = 1'b1;
                    if (neg_reg)
                    begin
                        rc_next = COEF_W'(0) - lo_reg;
                    end
                    else if (lo_reg > COEF_MAX)
                    begin
                        rc_next = COEF_MAX;
                    end
                    else
                    begin
                        rc_next = lo_reg;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            s1_valid_reg <= 1'b0;
            issued_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            sa_reg <= '0;
            sb_reg <= '0;
            saa_reg <= '0;
            sbb_reg <= '0;
            sab_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            s1_valid_reg <= q_pop;
            issued_reg <= issued_next;
            out_valid_reg <= out_valid_next;
            if (fin_load)
            begin
                sa_reg <= '0;
                sb_reg <= '0;
                saa_reg <= '0;
                sbb_reg <= '0;
                sab_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sa_reg <= sa_next;
                sb_reg <= sb_next;
                saa_reg <= saa_next;
                sbb_reg <= sbb_next;
                sab_reg <= sab_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_flags_reg <= q_flags;
            s1_a_reg <= q_a;
            s1_b_reg <= q_b;
            s1_aa_reg <= q_a * q_a;
            s1_bb_reg <= q_b * q_b;
            s1_ab_reg <= q_a * q_b;
        end
        if (fin_load)
        begin
            fin_sa_reg <= sa_next;
            fin_sb_reg <= sb_next;
            fin_saa_reg <= saa_next;
            fin_sbb_reg <= sbb_next;
            fin_sab_reg <= sab_next;
            fin_n_reg <= cnt_next;
        end
        t_reg <= t_next;
        va_reg <= va_next;
        vb_reg <= vb_next;
        cv_reg <= cv_next;
        prod_reg <= prod_next;
        rhs_reg <= rhs_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        mid_reg <= mid_next;
        dd_reg <= dd_next;
        neg_reg <= neg_next;
        rc_reg <= rc_next;
        rv_reg <= rv_next;
        if (out_load)
        begin
            out_corr_reg <= rc_reg;
            out_vres_reg <= rv_reg;
            out_cnt_reg <= fin_n_reg;
        end
    end

endmodule

`default_nettype wire

@@ src/pcw_checker.sv @@
// Port-level checks on the correlation core, bound to the top level.
// Depends on pcw_pkg and pearson_correlation_window_core.
`timescale 1ns / 1ps
`default_nettype none

module pcw_checker
    import pcw_pkg::*;
#(
    parameter int CNT_W = 21
) (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic signed [COEF_W-1:0] correlation,
    input wire logic                     valid_res,
    input wire logic [CNT_W-1:0]         pair_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(correlation)
            && $stable(valid_res) && $stable(pair_count))
        else $error("A stalled result transaction changed.");

    a_undefined_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> correlation == '0)
        else $error("An undefined coefficient is not zero.");

    a_valid_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> pair_count >= CNT_W'(2))
        else $error("A defined coefficient came from fewer than two pairs.");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("A result transaction was offered during reset.");

endmodule

bind pearson_correlation_window_core pcw_checker #(
    .CNT_W(CNT_W)
) u_pcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .correlation(correlation),
    .valid_res  (valid_res),
    .pair_count (pair_count)
);

`default_nettype wire
